// File: src/lofp_pkg.sv
// Package for the landmark/odometry pose fusion core: types, constants,
// the arctangent table and saturation helpers. Used by every module in src.
package lofp_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ITER_N = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
    localparam int CNT_W  = 5;
    localparam int VW     = 54;   // CORDIC vector width
    localparam int ZW     = 36;   // Q30 angle accumulator width
    localparam int DW     = 34;   // rotated delta width
    localparam int HW     = 22;   // rounded heading difference width

    localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [24:0]   GAIN_Q24    = 25'sd10188014;
    localparam logic [16:0]          WEIGHT_ONE  = 17'd65536;

    localparam logic [2:0] REG_ODOM_WEIGHT = 3'd0;
    localparam logic [2:0] REG_LANDMARK_X  = 3'd1;
    localparam logic [2:0] REG_LANDMARK_Y  = 3'd2;
    localparam logic [2:0] REG_REF_X       = 3'd3;
    localparam logic [2:0] REG_REF_Y       = 3'd4;
    localparam logic [2:0] REG_REF_HEADING = 3'd5;

    typedef logic signed [31:0] pos_t;
    typedef logic signed [19:0] ang_t;

    typedef struct packed {
        pos_t rx;
        pos_t ry;
        ang_t rh;
        logic lidar_valid;
        pos_t lx;
        pos_t ly;
    } item_t;

    typedef struct packed {
        pos_t ref_x;
        pos_t ref_y;
        ang_t ref_heading;
    } ref_cfg_t;

    typedef struct packed {
        logic [16:0] weight;
        pos_t        landmark_x;
        pos_t        landmark_y;
    } fuse_cfg_t;

    typedef struct packed {
        pos_t pose_x;
        pos_t pose_y;
        ang_t pose_heading;
    } pose_t;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [CNT_W-1:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0:    r = 36'sh03243F6A8;
            5'd1:    r = 36'sh01DAC6705;
            5'd2:    r = 36'sh00FADBAFC;
            5'd3:    r = 36'sh007F56EA6;
            5'd4:    r = 36'sh003FEAB76;
            5'd5:    r = 36'sh001FFD55B;
            5'd6:    r = 36'sh000FFFAAA;
            5'd7:    r = 36'sh0007FFF55;
            5'd8:    r = 36'sh0003FFFEA;
            5'd9:    r = 36'sh0001FFFFD;
            5'd10:   r = 36'sh0000FFFFF;
            5'd11:   r = 36'sh00007FFFF;
            5'd12:   r = 36'sh00003FFFF;
            5'd13:   r = 36'sh00001FFFF;
            5'd14:   r = 36'sh00000FFFF;
            5'd15:   r = 36'sh000007FFF;
            5'd16:   r = 36'sh000003FFF;
            5'd17:   r = 36'sh000001FFF;
            5'd18:   r = 36'sh000000FFF;
            5'd19:   r = 36'sh0000007FF;
            5'd20:   r = 36'sh0000003FF;
            5'd21:   r = 36'sh0000001FF;
            5'd22:   r = 36'sh0000000FF;
            5'd23:   r = 36'sh00000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic pos_t sat32(input logic signed [63:0] v);
        pos_t r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic ang_t sat20(input logic signed [63:0] v);
        ang_t r;
        if (v > 64'sd524287)
            r = 20'sh7FFFF;
        else if (v < -64'sd524288)
            r = 20'sh80000;
        else
            r = v[19:0];
        return r;
    endfunction

endpackage

// File: src/lofp_front.sv
// Front end: accepts input items, makes the odometry pose relative to the
// reference pose and holds the result for the queue. Depends on lofp_pkg.
module lofp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [151:0]       in_data,
    input  logic               in_flag,
    input  lofp_pkg::ref_cfg_t ref_cfg,
    output logic               push_valid,
    input  logic               push_ready,
    output lofp_pkg::item_t    push_item
);
    logic             slot_valid_reg;
    lofp_pkg::item_t  slot_reg;
    lofp_pkg::item_t  item_next;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [20:0] dh;

    assign in_ready   = !slot_valid_reg || push_ready;
    assign push_valid = slot_valid_reg;
    assign push_item  = slot_reg;

    always_comb
    begin
        dx = 33'(signed'(in_data[31:0])) - 33'(ref_cfg.ref_x);
        dy = 33'(signed'(in_data[63:32])) - 33'(ref_cfg.ref_y);
        dh = 21'(signed'(in_data[83:64])) - 21'(ref_cfg.ref_heading);
        item_next.rx          = lofp_pkg::sat32(64'(dx));
        item_next.ry          = lofp_pkg::sat32(64'(dy));
        item_next.rh          = lofp_pkg::sat20(64'(dh));
        item_next.lidar_valid = in_flag;
        item_next.lx          = in_data[115:84];
        item_next.ly          = in_data[147:116];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            slot_valid_reg <= 1'b1;
        else if (push_ready)
            slot_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            slot_reg <= item_next;
    end

endmodule

// File: src/lofp_queue.sv
// Two-entry item queue between the front end and the fusion engine.
// Depends on lofp_pkg.
module lofp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  lofp_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_pop,
    output lofp_pkg::item_t rd_item
);
    lofp_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 2'd1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

// File: src/lofp_back.sv
// Fusion engine: shared CORDIC unit for the rotation and both atan2 runs,
// gain multiply, blends and the output register. Depends on lofp_pkg.
module lofp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  lofp_pkg::item_t     q_item,
    input  lofp_pkg::fuse_cfg_t cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output lofp_pkg::pose_t     out_pose
);
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_PRE   = 13'b0000000000010,
        S_ROT   = 13'b0000000000100,
        S_GX1   = 13'b0000000001000,
        S_GX2   = 13'b0000000010000,
        S_GY1   = 13'b0000000100000,
        S_GY2   = 13'b0000001000000,
        S_VINIT = 13'b0000010000000,
        S_VITER = 13'b0000100000000,
        S_BH    = 13'b0001000000000,
        S_BX    = 13'b0010000000000,
        S_BY    = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [lofp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [lofp_pkg::VW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [lofp_pkg::ZW-1:0] z_reg, z_next, vd_reg, vd_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [lofp_pkg::DW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [lofp_pkg::HW-1:0] hl_reg, hl_next;
    logic second_reg, second_next;
    lofp_pkg::item_t item_reg, item_next;
    lofp_pkg::pose_t res_reg, res_next;
    lofp_pkg::ang_t  last_heading_reg, last_heading_next;
    logic out_valid_reg, out_valid_next;
    lofp_pkg::pose_t out_reg, out_next;

    logic signed [lofp_pkg::VW-1:0] xs, ys, msrc, vx0, vy0;
    logic signed [lofp_pkg::ZW-1:0] at, zr, zv, hl30, rot_z0;
    logic signed [lofp_pkg::DW-1:0] vsrc_x, vsrc_y;
    logic signed [24:0] mop;
    logic signed [49:0] mprod;
    logic signed [63:0] gsum;
    logic signed [35:0] ba, bb;
    logic signed [17:0] w, wc;
    logic signed [63:0] bsum, bshift;
    logic last_iter;

    assign out_valid = out_valid_reg;
    assign out_pose  = out_reg;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        xs        = x_reg >>> cnt_reg;
        ys        = y_reg >>> cnt_reg;
        at        = lofp_pkg::atan_q30(cnt_reg);
        last_iter = (cnt_reg == lofp_pkg::CNT_W'(lofp_pkg::ITER_N - 1));
        rot_z0    = {{2{last_heading_reg[19]}}, last_heading_reg, 14'b0};

        // gain multiply in two partial products: low 20 bits, then the rest
        msrc  = (state_reg == S_GX1 || state_reg == S_GX2) ? x_reg : y_reg;
        if (state_reg == S_GX1 || state_reg == S_GY1)
            mop = {5'b0, msrc[19:0]};
        else
            mop = {msrc[43], msrc[43:20]};
        mprod = mop * lofp_pkg::GAIN_Q24;
        gsum  = acc_reg + (64'(mprod) <<< 20) + 64'sd536870912;

        // atan2 operands
        if (second_reg)
        begin
            vsrc_x = lofp_pkg::DW'(item_reg.lx);
            vsrc_y = lofp_pkg::DW'(item_reg.ly);
        end
        else
        begin
            vsrc_x = dx_reg;
            vsrc_y = dy_reg;
        end
        vx0 = {{4{vsrc_x[lofp_pkg::DW-1]}}, vsrc_x, 16'b0};
        vy0 = {{4{vsrc_y[lofp_pkg::DW-1]}}, vsrc_y, 16'b0};

        // blend operands
        w  = (cfg.weight > lofp_pkg::WEIGHT_ONE) ? 18'sd65536 : 18'(cfg.weight);
        wc = 18'sd65536 - w;
        if (state_reg == S_BH)
        begin
            ba = 36'(item_reg.rh);
            bb = 36'(hl_reg);
        end
        else if (state_reg == S_BX)
        begin
            ba = 36'(item_reg.rx);
            bb = 36'(cfg.landmark_x) - 36'(dx_reg);
        end
        else
        begin
            ba = 36'(item_reg.ry);
            bb = 36'(cfg.landmark_y) - 36'(dy_reg);
        end
        bsum   = 64'(w) * 64'(ba) + 64'(wc) * 64'(bb) + 64'sd32768;
        bshift = bsum >>> 16;
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        z_next            = z_reg;
        vd_next           = vd_reg;
        acc_next          = acc_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        hl_next           = hl_reg;
        second_next       = second_reg;
        item_next         = item_reg;
        res_next          = res_reg;
        last_heading_next = last_heading_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_next          = out_reg;
        zr                = z_reg;
        zv                = z_reg;
        hl30              = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    item_next = q_item;
                    if (q_item.lidar_valid)
                    begin
                        x_next      = lofp_pkg::VW'(q_item.lx) <<< 6;
                        y_next      = lofp_pkg::VW'(q_item.ly) <<< 6;
                        z_next      = rot_z0;
                        cnt_next    = '0;
                        second_next = 1'b0;
                        state_next  = S_PRE;
                    end
                    else
                    begin
                        res_next.pose_x       = q_item.rx;
                        res_next.pose_y       = q_item.ry;
                        res_next.pose_heading = q_item.rh;
                        state_next            = S_DONE;
                    end
                end
            end
            S_PRE:
            begin
                // fold the angle toward the CORDIC range, four passes
                if (z_reg > lofp_pkg::HALF_PI_Q30)
                begin
                    z_next = z_reg - lofp_pkg::PI_Q30;
                    x_next = -x_reg;
                    y_next = -y_reg;
                end
                else if (z_reg < -lofp_pkg::HALF_PI_Q30)
                begin
                    z_next = z_reg + lofp_pkg::PI_Q30;
                    x_next = -x_reg;
                    y_next = -y_reg;
                end
                if (cnt_reg == lofp_pkg::CNT_W'(3))
                begin
                    cnt_next   = '0;
                    state_next = S_ROT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_ROT:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
                if (last_iter)
                begin
                    cnt_next   = '0;
                    state_next = S_GX1;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_GX1:
            begin
                acc_next   = 64'(mprod);
                state_next = S_GX2;
            end
            S_GX2:
            begin
                dx_next    = lofp_pkg::DW'(gsum >>> 30);
                state_next = S_GY1;
            end
            S_GY1:
            begin
                acc_next   = 64'(mprod);
                state_next = S_GY2;
            end
            S_GY2:
            begin
                dy_next    = lofp_pkg::DW'(gsum >>> 30);
                state_next = S_VINIT;
            end
            S_VINIT:
            begin
                cnt_next = '0;
                if (vsrc_x == 0 && vsrc_y == 0)
                begin
                    zv = '0;
                    if (!second_reg)
                    begin
                        vd_next     = zv;
                        second_next = 1'b1;
                    end
                    else
                    begin
                        hl30       = vd_reg - zv;
                        hl_next    = lofp_pkg::HW'((hl30 + 36'sd8192) >>> 14);
                        state_next = S_BH;
                    end
                end
                else
                begin
                    if (vsrc_x < 0)
                    begin
                        z_next = (vsrc_y >= 0) ? lofp_pkg::PI_Q30 : -lofp_pkg::PI_Q30;
                        x_next = -vx0;
                        y_next = -vy0;
                    end
                    else
                    begin
                        z_next = '0;
                        x_next = vx0;
                        y_next = vy0;
                    end
                    state_next = S_VITER;
                end
            end
            S_VITER:
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    zr     = z_reg + at;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    zr     = z_reg - at;
                end
                z_next = zr;
                if (last_iter)
                begin
                    cnt_next = '0;
                    if (!second_reg)
                    begin
                        vd_next     = zr;
                        second_next = 1'b1;
                        state_next  = S_VINIT;
                    end
                    else
                    begin
                        hl30       = vd_reg - zr;
                        hl_next    = lofp_pkg::HW'((hl30 + 36'sd8192) >>> 14);
                        state_next = S_BH;
                    end
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_BH:
            begin
                res_next.pose_heading = lofp_pkg::sat20(bshift);
                state_next            = S_BX;
            end
            S_BX:
            begin
                res_next.pose_x = lofp_pkg::sat32(bshift);
                state_next      = S_BY;
            end
            S_BY:
            begin
                res_next.pose_y = lofp_pkg::sat32(bshift);
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next          = res_reg;
                    out_valid_next    = 1'b1;
                    last_heading_next = res_reg.pose_heading;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            second_reg       <= 1'b0;
            last_heading_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            second_reg       <= second_next;
            last_heading_reg <= last_heading_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        vd_reg   <= vd_next;
        acc_reg  <= acc_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        hl_reg   <= hl_next;
        item_reg <= item_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule

// File: src/landmark_odometry_pose_fusion_core.sv
// Top level of the landmark/odometry pose fusion core: configuration
// registers, front end, item queue and fusion engine. Depends on lofp_pkg.
//
// Channel   Direction  Handshake                Payload
// s_axis    in         s_axis_tvalid/tready     tdata odometry + landmark obs, tuser flag
// m_axis    out        m_axis_tvalid/tready     tdata fused pose
// cfg       in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// An item without an observation goes straight to the output register; one
// with an observation runs the rotation and two atan2 on the single shared
// CORDIC unit, N = 16 CORDIC steps each and fewer when a vector is zero.
// Reset clears control state and restores register defaults;
// no memory sweep. The front end and the two-entry queue keep taking items
// while the engine works, and a finished pose waits in the output register
// while the next item starts. cfg_ready is always high.
module landmark_odometry_pose_fusion_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // odom_x[31:0] odom_y[63:32] odom_heading[83:64] lidar_x[115:84]
    // lidar_y[147:116], zero pad [151:148]
    input  logic [151:0] s_axis_tdata,
    // lidar_valid[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pose_x[31:0] pose_y[63:32] pose_heading[83:64], zero pad [87:84]
    output logic [87:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    lofp_pkg::ref_cfg_t  ref_cfg_reg;
    lofp_pkg::fuse_cfg_t fuse_cfg_reg;
    logic            push_valid;
    logic            push_ready;
    lofp_pkg::item_t push_item;
    logic            q_valid;
    logic            q_pop;
    lofp_pkg::item_t q_item;
    lofp_pkg::pose_t out_pose;

    assign cfg_ready = 1'b1;

    // Configuration writes; out-of-range indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fuse_cfg_reg.weight     <= 17'd32768;
            fuse_cfg_reg.landmark_x <= '0;
            fuse_cfg_reg.landmark_y <= '0;
            ref_cfg_reg.ref_x       <= '0;
            ref_cfg_reg.ref_y       <= '0;
            ref_cfg_reg.ref_heading <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lofp_pkg::REG_ODOM_WEIGHT: fuse_cfg_reg.weight     <= cfg_data[16:0];
                lofp_pkg::REG_LANDMARK_X:  fuse_cfg_reg.landmark_x <= cfg_data;
                lofp_pkg::REG_LANDMARK_Y:  fuse_cfg_reg.landmark_y <= cfg_data;
                lofp_pkg::REG_REF_X:       ref_cfg_reg.ref_x       <= cfg_data;
                lofp_pkg::REG_REF_Y:       ref_cfg_reg.ref_y       <= cfg_data;
                lofp_pkg::REG_REF_HEADING: ref_cfg_reg.ref_heading <= cfg_data[19:0];
                default:                   ;
            endcase
        end
    end

    // Accept and make relative to the reference pose
    lofp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_flag    (s_axis_tuser),
        .ref_cfg    (ref_cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decouple the front end from the engine
    lofp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_item)
    );

    // Rotate, take both angles, blend and hold the result
    lofp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .cfg       (fuse_cfg_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pose  (out_pose)
    );

    assign m_axis_tdata = {4'b0, out_pose.pose_heading, out_pose.pose_y, out_pose.pose_x};

endmodule
